[rtl/core/mm_pkg.sv]
package mm_pkg;
  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 40;
  localparam int IDX_W = 3;
  localparam int CFG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;
endpackage

[rtl/core/mm_if.sv]
interface mm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] element;
  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface mm_out_if;
  logic valid;
  logic ready;
  logic signed [39:0] product;
  logic [2:0] row;
  logic [2:0] col;
  logic last;
  modport source (output valid, output product, output row, output col, output last,
                  input ready);
  modport sink (input valid, input product, input row, input col, input last,
                output ready);
endinterface

interface mm_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/mm_cell.sv]
// One multiply-accumulate cell: takes a product operand pair and passes its
// A operand on to the next cell.
module mm_cell (
  input  logic                            clk,
  input  mm_pkg::cell_ctrl_t              ctrl,
  input  logic signed [mm_pkg::ELEM_W-1:0] a_in,
  input  logic signed [mm_pkg::ELEM_W-1:0] b_in,
  input  logic                            en,
  output logic signed [mm_pkg::ELEM_W-1:0] a_out,
  output logic signed [mm_pkg::PROD_W-1:0] acc
);
  import mm_pkg::*;
  logic signed [ELEM_W-1:0] a_r;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [2*ELEM_W-1:0] prod;

  assign prod = a_in * b_in;
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) acc_nxt = '0;
    else if (ctrl.shift && en) acc_nxt = acc_r + PROD_W'(prod);
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctrl.shift) a_r <= a_in;
  end
  assign a_out = a_r;
  assign acc = acc_r;
endmodule

[rtl/core/matrix_multiply.sv]
// Channel | dir | payload
// in      | in  | element
// out     | out | product, row, col, last
// cfg     | in  | index, data
// Load: m*n + n*p elements, one per cycle while cfg.valid is low (it holds in.ready low).
// Compute per row of C: a chain of MAX_DIM cells,
// one cell per column of C; each cell holds one dot-product accumulator
// and its column of B.
// Then p output transactions per row, each stalled by out.ready.
// Reset clears sizes to 8 and restarts the load; stores are not cleared.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input logic clk,
  input logic rst_n,
  mm_in_if.sink in_ch,
  mm_out_if.source out_ch,
  mm_cfg_if.sink cfg_ch
);
  import mm_pkg::*;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(2 * DEPTH + 1);

  logic [CFG_W-1:0] rows_r, inner_r, cols_r;
  logic [DW-1:0] m, n, p;
  state_t state_r, state_nxt;
  logic [CW-1:0] load_r, load_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IW-1:0] bk_r, bk_nxt, bc_r, bc_nxt;
  logic [DW:0] k_r, k_nxt;
  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd;
  logic signed [ELEM_W-1:0] chain [MAX_DIM+1];
  logic signed [PROD_W-1:0] accs [MAX_DIM];
  cell_ctrl_t ctrl;
  logic [CW-1:0] size_a, size_ab;
  logic in_fire, cfg_fire, out_fire, cfg_hit, b_we;

  function automatic logic [DW-1:0] clampd(input logic [CFG_W-1:0] v);
    if (v == '0) return DW'(1);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  assign m = clampd(rows_r);
  assign n = clampd(inner_r);
  assign p = clampd(cols_r);
  assign size_a = CW'(m) * CW'(n);
  assign size_ab = CW'(m) * CW'(n) + CW'(n) * CW'(p);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit = cfg_fire && (cfg_ch.index inside {REG_ROWS_A, REG_INNER_DIM, REG_COLS_B});
  assign out_fire = out_ch.valid && out_ch.ready;
  assign b_we = in_fire && (load_r >= size_a);
  assign in_ch.ready = (state_r == ST_LOAD) && !cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(8);
      inner_r <= CFG_W'(8);
      cols_r <= CFG_W'(8);
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_ROWS_A: rows_r <= cfg_ch.data;
        REG_INNER_DIM: inner_r <= cfg_ch.data;
        REG_COLS_B: cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A store writes (each cell writes its own column of B)
  always_ff @(posedge clk) begin
    if (in_fire && (load_r < size_a)) a_mem[AW'(load_r)] <= in_ch.element;
  end

  // compute step k: a_rd holds A(i,k-1); cell c sees A(i,k-1-c) and
  // reads B(k-1-c,c) from its own column store through a register (b_rd).
  always_ff @(posedge clk) begin
    a_rd <= a_mem[AW'(32'(i_r) * 32'(n) + 32'(k_r))];
  end

  assign chain[0] = a_rd;
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    logic signed [ELEM_W-1:0] col_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] b_rd;
    logic [DW:0] kk;
    logic valid_k;

    always_comb kk = k_r - (DW+1)'(c);
    always_ff @(posedge clk) begin
      if (b_we && (bc_r == IW'(c))) col_mem[bk_r] <= in_ch.element;
      b_rd <= col_mem[IW'(kk)];
      valid_k <= (state_r == ST_CALC) && (k_r >= (DW+1)'(c)) &&
                 (kk < (DW+1)'(n)) && (c < 32'(p));
    end

    mm_cell u_cell (
      .clk(clk), .ctrl(ctrl), .a_in(chain[c]), .b_in(b_rd),
      .en(valid_k), .a_out(chain[c+1]), .acc(accs[c])
    );
  end

  always_comb begin
    state_nxt = state_r;
    load_nxt = load_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    bk_nxt = bk_r;
    bc_nxt = bc_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_r >= size_a) begin
            if (32'(bc_r) == 32'(p) - 1) begin
              bc_nxt = '0;
              bk_nxt = bk_r + IW'(1);
            end else begin
              bc_nxt = bc_r + IW'(1);
            end
          end
          load_nxt = load_r + CW'(1);
          if (load_nxt == size_ab) begin
            load_nxt = '0;
            bk_nxt = '0;
            bc_nxt = '0;
            state_nxt = ST_CALC;
            i_nxt = '0;
            k_nxt = '0;
          end
        end
      end
      ST_CALC: begin
        k_nxt = k_r + (DW+1)'(1);
        if (k_r == (DW+1)'(32'(n) + MAX_DIM + 1)) begin
          state_nxt = ST_OUT;
          j_nxt = '0;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          j_nxt = j_r + IW'(1);
          if (32'(j_r) == 32'(p) - 1) begin
            if (32'(i_r) == 32'(m) - 1) state_nxt = ST_LOAD;
            else begin
              state_nxt = ST_CALC;
              i_nxt = i_r + IW'(1);
              k_nxt = '0;
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_hit) begin
      state_nxt = ST_LOAD;
      load_nxt = '0;
      bk_nxt = '0;
      bc_nxt = '0;
    end
  end

  always_comb begin
    ctrl.clear = (state_r == ST_CALC) && (k_r == '0);
    ctrl.shift = (state_r == ST_CALC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      load_r <= '0;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      bk_r <= '0;
      bc_r <= '0;
    end else begin
      state_r <= state_nxt;
      load_r <= load_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      bk_r <= bk_nxt;
      bc_r <= bc_nxt;
    end
  end

  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.product = accs[j_r];
  assign out_ch.row = 3'(i_r);
  assign out_ch.col = 3'(j_r);
  assign out_ch.last = (32'(i_r) == 32'(m) - 1) && (32'(j_r) == 32'(p) - 1);

  a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("load during output");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last && !cfg_fire |=> state_r == ST_LOAD)
    else $error("no return to load");
  a_load_rng: assert property (@(posedge clk) disable iff (!rst_n)
    load_r < size_ab || state_r != ST_LOAD || $past(cfg_fire))
    else $error("load count overrun");
endmodule

[tb/sv/matrix_multiply_tb.sv]
`timescale 1ns / 100ps

module matrix_multiply_tb;
  import mm_pkg::*;

  class mm_scoreboard;
    int unsigned rows_cfg, inner_cfg, cols_cfg;
    logic signed [ELEM_W-1:0] a_mat[64];
    logic signed [ELEM_W-1:0] b_mat[64];
    int unsigned loaded;
    logic [PROD_W-1:0] exp_prod[$];
    logic [IDX_W-1:0] exp_row[$];
    logic [IDX_W-1:0] exp_col[$];
    logic exp_last[$];
    int unsigned products_seen;
    int errors;

    function new();
      rows_cfg = 8;
      inner_cfg = 8;
      cols_cfg = 8;
      loaded = 0;
      products_seen = 0;
      errors = 0;
    endfunction

    task report_error(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function int unsigned eff_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_ROWS_A: rows_cfg = 32'(val);
        REG_INNER_DIM: inner_cfg = 32'(val);
        REG_COLS_B: cols_cfg = 32'(val);
        default: return;
      endcase
      loaded = 0;
    endfunction

    function void note_element(logic signed [ELEM_W-1:0] e);
      int unsigned m, n, p, sa, sb;
      logic signed [PROD_W-1:0] acc;
      m = eff_dim(rows_cfg);
      n = eff_dim(inner_cfg);
      p = eff_dim(cols_cfg);
      sa = m * n;
      sb = n * p;
      if (loaded < sa) a_mat[loaded] = e;
      else b_mat[loaded - sa] = e;
      loaded++;
      if (loaded < sa + sb) return;
      loaded = 0;
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = '0;
          for (int k = 0; k < n; k++)
            acc += PROD_W'(a_mat[i*n+k]) * PROD_W'(b_mat[k*p+j]);
          exp_prod.push_back(acc);
          exp_row.push_back(i[IDX_W-1:0]);
          exp_col.push_back(j[IDX_W-1:0]);
          exp_last.push_back(i == m - 1 && j == p - 1);
        end
      end
    endfunction

    function int unsigned pending();
      return exp_prod.size();
    endfunction

    task check_product(logic [PROD_W-1:0] prod, logic [IDX_W-1:0] r,
                       logic [IDX_W-1:0] c, logic lst);
      logic [PROD_W-1:0] ep;
      logic [IDX_W-1:0] er, ec;
      logic el;
      products_seen++;
      if (exp_prod.size() == 0) begin
        report_error($sformatf("unexpected transaction prod=%0h", prod));
        return;
      end
      ep = exp_prod.pop_front();
      er = exp_row.pop_front();
      ec = exp_col.pop_front();
      el = exp_last.pop_front();
      if (prod !== ep) report_error($sformatf("product %0h exp %0h", prod, ep));
      if (r !== er) report_error($sformatf("row %0d exp %0d", r, er));
      if (c !== ec) report_error($sformatf("col %0d exp %0d", c, ec));
      if (lst !== el) report_error($sformatf("last %0b exp %0b", lst, el));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  int cycles = 0;
  bit hold_out = 0;
  bit stim_done = 0;
  int in_count = 0;
  mm_scoreboard sb;

  mm_in_if in_ch();
  mm_out_if out_ch();
  mm_cfg_if cfg_ch();

  matrix_multiply i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.element = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
    sb = new();
  end

  task send_element(logic signed [ELEM_W-1:0] e, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.element <= e;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_element(e);
    in_count++;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_ch.valid <= 0;
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_size(idx, val);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task drain();
    in_ch.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task set_sizes(int unsigned m, int unsigned n, int unsigned p);
    drain();
    write_reg(REG_ROWS_A, CFG_W'(m));
    write_reg(REG_INNER_DIM, CFG_W'(n));
    write_reg(REG_COLS_B, CFG_W'(p));
  endtask

  function int unsigned pass_len();
    int unsigned m, n, p;
    m = sb.eff_dim(sb.rows_cfg);
    n = sb.eff_dim(sb.inner_cfg);
    p = sb.eff_dim(sb.cols_cfg);
    return m * n + n * p;
  endfunction

  function logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task run_pass(bit no_gap = 0);
    int unsigned len;
    len = pass_len();
    for (int i = 0; i < len; i++) send_element(rand_elem(), no_gap);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 2) == 0) w = 0;
        if (w > 0) begin
          out_ch.ready <= 0;
          repeat (w) @(posedge clk);
        end
        out_ch.ready <= 1;
        do @(posedge clk); while (!out_ch.valid);
        sb.check_product(out_ch.product, out_ch.row, out_ch.col, out_ch.last);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("timeout after %0d cycles", cycles);
        $display("matrix_multiply regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: 1x1x1 extremes and max-negative squared.
    set_sizes(1, 1, 1);
    send_element(16'sh8000); send_element(16'sh8000);
    send_element(16'sh7fff); send_element(16'sh8000);
    send_element(16'sh0000); send_element(16'sh7fff);
    send_element(16'shffff); send_element(16'sh0001);
    // Zero sizes act as one, 15 acts as eight (row and column indices stay in 0..7).
    set_sizes(0, 0, 0);
    send_element(16'sh0100); send_element(16'sh5555);
    set_sizes(2, 1, 15);
    run_pass(1);
    // Register write mid-load restarts the load.
    set_sizes(2, 2, 2);
    send_element(16'sh1234); send_element(16'shedcb);
    write_reg(REG_COLS_B, CFG_W'(1));
    run_pass();
    // Max sizes, back-to-back.
    set_sizes(8, 8, 8);
    run_pass(1);
    // Long receiver hold-off while the sender keeps offering passes.
    set_sizes(2, 2, 2);
    fork
      begin
        hold_out = 1;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      begin
        run_pass(1);
        run_pass(1);
        run_pass(1);
      end
    join
    drain();

    // Random phases, mostly small sizes.
    while (in_count < 280) begin
      if ($urandom_range(0, 7) == 0)
        set_sizes($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      else
        set_sizes($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
      repeat ($urandom_range(1, 3)) run_pass();
    end
    drain();

    $display("covered %0d element transactions, %0d product transactions",
             in_count, sb.products_seen);
    $display("sizes 0..15 incl. clamped extremes, mid-load restart, long output stall");
    if (sb.errors == 0) begin
      $display("matrix_multiply regression: pass");
    end else begin
      $display("matrix_multiply regression: fail");
    end
    $finish;
  end
endmodule

[matrix_multiply.f]
rtl/core/mm_pkg.sv
rtl/core/mm_if.sv
rtl/core/mm_cell.sv
rtl/core/matrix_multiply.sv
tb/sv/matrix_multiply_tb.sv
